// ===== rtl/vis_pkg.sv =====
`timescale 1ns / 1ps

package vis_pkg;

   // Default sizing
   localparam int LAST_VECTOR_DEF  = 57;
   localparam int ENABLE_WORDS_DEF = 3;

   // Command codes carried on req_tuser
   typedef enum logic [2:0] {
      CMD_SET_PENDING  = 3'd0,
      CMD_SCB_READ     = 3'd1,
      CMD_SCB_WRITE    = 3'd2,
      CMD_ENABLE_READ  = 3'd3,
      CMD_ENABLE_WRITE = 3'd4,
      CMD_EVALUATE     = 3'd5
   } cmd_type;

   // System control block map
   localparam logic [7:0]  OFF_ICSR       = 8'h04;
   localparam logic [7:0]  OFF_VTOR       = 8'h08;
   localparam logic [7:0]  OFF_SHPR3      = 8'h20;
   localparam logic [7:0]  OFF_SHCSR      = 8'h24;
   localparam logic [7:0]  OFF_MPU_TYPE   = 8'h90;
   localparam logic [31:0] MPU_TYPE_VALUE = 32'h0000_0800;

   // ICSR PendSV set bit
   localparam int PENDSV_SET_BIT = 28;

   // Fixed system vectors
   localparam logic [5:0] VEC_SVC     = 6'd11;
   localparam logic [5:0] VEC_PENDSV  = 6'd14;
   localparam logic [5:0] VEC_SYSTICK = 6'd15;

   // External vectors start here and run to the top of the 64-bit mask
   localparam int FIRST_EXTERNAL = 16;
   localparam int EXT_COUNT      = 64 - FIRST_EXTERNAL;

   // Stream layout
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;
   localparam int REQ_VEC_LSB   = 0;
   localparam int REQ_OFF_LSB   = 6;
   localparam int REQ_DATA_LSB  = 14;
   localparam int REQ_MASK_BIT  = 46;
   localparam int REQ_HAND_BIT  = 47;
   localparam int REQ_SHAD_BIT  = 48;
   localparam int RSP_TAKE_BIT  = 32;
   localparam int RSP_VEC_LSB   = 33;
   localparam int RSP_RECHK_BIT = 39;

   typedef struct packed {
      cmd_type     command;
      logic [5:0]  vector_number;
      logic [7:0]  reg_offset;
      logic [31:0] write_data;
      logic        blocked;
   } req_type;

   // Packed so that it maps straight onto rsp_tdata, read_data lowest
   typedef struct packed {
      logic        recheck_needed;
      logic [5:0]  take_vector;
      logic        take_valid;
      logic [31:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic       found;
      logic [5:0] vector;
      logic       pendsv;
   } sel_type;

endpackage

// ===== rtl/vis_select.sv =====
`timescale 1ns / 1ps

module vis_select #(
   parameter int LAST_VECTOR  = vis_pkg::LAST_VECTOR_DEF,
   parameter int ENABLE_WORDS = vis_pkg::ENABLE_WORDS_DEF
) (
   input  logic [63:0]       pending,
   input  logic [31:0]       enable_words [ENABLE_WORDS],
   output vis_pkg::sel_type  sel
);

   logic [vis_pkg::EXT_COUNT-1:0] ext_cand;
   logic [5:0]                    ext_idx;

   // Mask each external vector by range and by its enable bit
   for (genvar j = 0; j < vis_pkg::EXT_COUNT; j++) begin : g_cand
      localparam int W = j / 32;
      localparam int B = j % 32;
      if ((j + vis_pkg::FIRST_EXTERNAL < LAST_VECTOR) && (W < ENABLE_WORDS)) begin : g_on
         assign ext_cand[j] = pending[j + vis_pkg::FIRST_EXTERNAL] & enable_words[W][B];
      end else begin : g_off
         assign ext_cand[j] = 1'b0;
      end
   end

   // Lowest set candidate wins
   always_comb begin
      ext_idx = '0;
      for (int i = vis_pkg::EXT_COUNT - 1; i >= 0; i--) begin
         if (ext_cand[i]) ext_idx = 6'(i);
      end
   end

   always_comb begin
      sel = '0;
      if (pending[vis_pkg::VEC_SVC]) begin
         sel.found  = 1'b1;
         sel.vector = vis_pkg::VEC_SVC;
      end else if (pending[vis_pkg::VEC_SYSTICK]) begin
         sel.found  = 1'b1;
         sel.vector = vis_pkg::VEC_SYSTICK;
      end else if (pending[vis_pkg::VEC_PENDSV]) begin
         sel.found  = 1'b1;
         sel.vector = vis_pkg::VEC_PENDSV;
         sel.pendsv = 1'b1;
      end else if (|ext_cand) begin
         sel.found  = 1'b1;
         sel.vector = 6'(vis_pkg::FIRST_EXTERNAL) + ext_idx;
      end
   end

endmodule

// ===== rtl/vis_core.sv =====
`timescale 1ns / 1ps

module vis_core #(
   parameter int LAST_VECTOR  = vis_pkg::LAST_VECTOR_DEF,
   parameter int ENABLE_WORDS = vis_pkg::ENABLE_WORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  vis_pkg::req_type req,
   output vis_pkg::rsp_type rsp
);

   logic [63:0] pending_ff, pending_in;
   logic [31:0] icsr_ff, icsr_in;
   logic [31:0] vtor_ff, vtor_in;
   logic [31:0] shpr3_ff, shpr3_in;
   logic [31:0] shcsr_ff, shcsr_in;
   logic [31:0] enable_ff [ENABLE_WORDS];
   logic [31:0] enable_in [ENABLE_WORDS];
   logic        recheck_ff, recheck_in;

   logic [63:0]      pend_eval;
   logic [5:0]       word_idx;
   vis_pkg::sel_type sel;

   always_comb begin
      pend_eval = pending_ff;
      pend_eval[vis_pkg::VEC_PENDSV] = pending_ff[vis_pkg::VEC_PENDSV] |
                                       icsr_ff[vis_pkg::PENDSV_SET_BIT];
   end

   vis_select #(
      .LAST_VECTOR  (LAST_VECTOR),
      .ENABLE_WORDS (ENABLE_WORDS)
   ) u_select (
      .pending      (pend_eval),
      .enable_words (enable_ff),
      .sel          (sel)
   );

   assign word_idx = req.reg_offset[7:2];

   always_comb begin
      pending_in = pending_ff;
      icsr_in    = icsr_ff;
      vtor_in    = vtor_ff;
      shpr3_in   = shpr3_ff;
      shcsr_in   = shcsr_ff;
      recheck_in = recheck_ff;
      for (int w = 0; w < ENABLE_WORDS; w++) enable_in[w] = enable_ff[w];
      rsp = '0;

      case (req.command)
         vis_pkg::CMD_SET_PENDING: begin
            pending_in[req.vector_number] = 1'b1;
            recheck_in = 1'b1;
         end
         vis_pkg::CMD_SCB_READ: begin
            unique case (req.reg_offset)
               vis_pkg::OFF_ICSR:     rsp.read_data = icsr_ff;
               vis_pkg::OFF_VTOR:     rsp.read_data = vtor_ff;
               vis_pkg::OFF_SHPR3:    rsp.read_data = shpr3_ff;
               vis_pkg::OFF_SHCSR:    rsp.read_data = shcsr_ff;
               vis_pkg::OFF_MPU_TYPE: rsp.read_data = vis_pkg::MPU_TYPE_VALUE;
               default:               rsp.read_data = '0;
            endcase
         end
         vis_pkg::CMD_SCB_WRITE: begin
            unique case (req.reg_offset)
               vis_pkg::OFF_ICSR: begin
                  icsr_in    = req.write_data;
                  recheck_in = 1'b1;
               end
               vis_pkg::OFF_VTOR:  vtor_in  = req.write_data;
               vis_pkg::OFF_SHPR3: shpr3_in = req.write_data;
               vis_pkg::OFF_SHCSR: shcsr_in = req.write_data;
               default: ;
            endcase
         end
         vis_pkg::CMD_ENABLE_READ: begin
            for (int w = 0; w < ENABLE_WORDS; w++) begin
               if (word_idx == 6'(w)) rsp.read_data = enable_ff[w];
            end
         end
         vis_pkg::CMD_ENABLE_WRITE: begin
            // set-only: OR the data in
            for (int w = 0; w < ENABLE_WORDS; w++) begin
               if (word_idx == 6'(w)) enable_in[w] = enable_ff[w] | req.write_data;
            end
         end
         vis_pkg::CMD_EVALUATE: begin
            pending_in = pend_eval;
            if ((pend_eval == '0) || req.blocked) begin
               recheck_in = (pend_eval != '0);
            end else begin
               recheck_in = 1'b0;
               if (sel.found) begin
                  pending_in[sel.vector] = 1'b0;
                  rsp.take_valid  = 1'b1;
                  rsp.take_vector = sel.vector;
               end
               if (sel.pendsv) icsr_in[vis_pkg::PENDSV_SET_BIT] = 1'b0;
            end
         end
         default: ;
      endcase

      rsp.recheck_needed = recheck_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         icsr_ff    <= '0;
         vtor_ff    <= '0;
         shpr3_ff   <= '0;
         shcsr_ff   <= '0;
         recheck_ff <= 1'b0;
         for (int w = 0; w < ENABLE_WORDS; w++) enable_ff[w] <= '0;
      end else if (fire) begin
         pending_ff <= pending_in;
         icsr_ff    <= icsr_in;
         vtor_ff    <= vtor_in;
         shpr3_ff   <= shpr3_in;
         shcsr_ff   <= shcsr_in;
         recheck_ff <= recheck_in;
         for (int w = 0; w < ENABLE_WORDS; w++) enable_ff[w] <= enable_in[w];
      end
   end

endmodule

// ===== rtl/vectored_interrupt_selector.sv =====
`timescale 1ns / 1ps

// Vectored interrupt selector: takes one command per clock (set pending, system control
// and enable register reads and writes, evaluate) and returns exactly one result per
// command, in order. A command goes through an input register and a result register; its
// result is registered once the result register is free or being drained. A new command
// can be taken every cycle as long as results are drained. The priority encode of the
// pending mask is combinational and sits between the two registers. SVC wins over SysTick,
// SysTick over PendSV, and PendSV over the lowest enabled pending external vector.
module vectored_interrupt_selector #(
   parameter int LAST_VECTOR  = vis_pkg::LAST_VECTOR_DEF,
   parameter int ENABLE_WORDS = vis_pkg::ENABLE_WORDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // vector_number[5:0], reg_offset[13:6], write_data[45:14], mask_active[46],
   // handler_active[47], shadow_active[48], zero pad[55:49]
   input  logic [vis_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command[2:0]
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_data[31:0], take_valid[32], take_vector[38:33], recheck_needed[39]
   output logic [vis_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic             in_valid_ff, in_valid_in;
   vis_pkg::req_type in_req_ff, in_req_in;
   logic             out_valid_ff, out_valid_in;
   vis_pkg::rsp_type out_rsp_ff, out_rsp_in;

   logic             accept;
   logic             advance;
   vis_pkg::rsp_type core_rsp;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_req_in               = in_req_ff;
      in_valid_in             = in_valid_ff;
      out_rsp_in              = out_rsp_ff;
      out_valid_in            = out_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (accept) begin
         in_valid_in             = 1'b1;
         in_req_in.command       = vis_pkg::cmd_type'(req_tuser);
         in_req_in.vector_number = req_tdata[vis_pkg::REQ_VEC_LSB +: 6];
         in_req_in.reg_offset    = req_tdata[vis_pkg::REQ_OFF_LSB +: 8];
         in_req_in.write_data    = req_tdata[vis_pkg::REQ_DATA_LSB +: 32];
         in_req_in.blocked       = req_tdata[vis_pkg::REQ_MASK_BIT] |
                                   req_tdata[vis_pkg::REQ_HAND_BIT] |
                                   req_tdata[vis_pkg::REQ_SHAD_BIT];
      end
      if (rsp_tready) out_valid_in = 1'b0;
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = core_rsp;
      end
   end

   vis_core #(
      .LAST_VECTOR  (LAST_VECTOR),
      .ENABLE_WORDS (ENABLE_WORDS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_rsp_ff;

endmodule

// ===== rtl/vis_checker.sv =====
`timescale 1ns / 1ps

module vis_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vis_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic       take;
   logic [5:0] vec;
   logic       rechk;

   assign take  = rsp_tdata[vis_pkg::RSP_TAKE_BIT];
   assign vec   = rsp_tdata[vis_pkg::RSP_VEC_LSB +: 6];
   assign rechk = rsp_tdata[vis_pkg::RSP_RECHK_BIT];

   // stalled transaction holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a taken vector is one the selection can pick
   a_take_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && take |-> (vec == vis_pkg::VEC_SVC) || (vec == vis_pkg::VEC_PENDSV) ||
                             (vec == vis_pkg::VEC_SYSTICK) || (vec[5:4] != 2'b00))
      else $error("taken vector is not selectable");

   // no take reports vector zero
   a_no_take_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !take |-> vec == 6'd0)
      else $error("vector reported without a take");

   // a take leaves recheck clear
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && take |-> !rechk)
      else $error("recheck set after a take");

endmodule

bind vectored_interrupt_selector vis_checker u_vis_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/vectored_interrupt_selector_tb.sv =====
`timescale 1ns / 1ps

module vectored_interrupt_selector_tb;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 60000;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      vis_pkg::cmd_type cmd;
      logic [5:0]       vec;
      logic [7:0]       off;
      logic [31:0]      data;
      logic [2:0]       hold;    // {shadow, handler, mask}
      logic             fixed;
      vis_pkg::rsp_type want;
   } stim_row_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [vis_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [2:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vis_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the controller state
   logic [63:0] pend_bits;
   logic [31:0] icsr_word, vtor_word, shpr3_word, shcsr_word;
   logic [31:0] enable_bits [vis_pkg::ENABLE_WORDS_DEF];
   logic        recheck_bit;

   vis_pkg::rsp_type expected_outcomes [$];
   stim_row_type     directed_rows [$];
   int               error_count  = 0;
   int               cycle_count  = 0;
   bit               gaps_on      = 1'b1;
   bit               hold_request = 1'b0;

   vectored_interrupt_selector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vectored_interrupt_selector_tb: done, errors");
         $finish;
      end
   end

   function automatic vis_pkg::rsp_type outcome(logic [31:0] rd, logic tv, logic [5:0] vn,
                                                logic rc);
      vis_pkg::rsp_type r;
      r.read_data      = rd;
      r.take_valid     = tv;
      r.take_vector    = vn;
      r.recheck_needed = rc;
      return r;
   endfunction

   function automatic stim_row_type row(vis_pkg::cmd_type c, logic [5:0] v, logic [7:0] o,
                                        logic [31:0] d, logic [2:0] h, logic fx,
                                        vis_pkg::rsp_type w);
      stim_row_type s;
      s.cmd   = c;
      s.vec   = v;
      s.off   = o;
      s.data  = d;
      s.hold  = h;
      s.fixed = fx;
      s.want  = w;
      return s;
   endfunction

   task automatic clear_state();
      pend_bits   = '0;
      icsr_word   = '0;
      vtor_word   = '0;
      shpr3_word  = '0;
      shcsr_word  = '0;
      recheck_bit = 1'b0;
      for (int i = 0; i < vis_pkg::ENABLE_WORDS_DEF; i++) enable_bits[i] = '0;
   endtask

   // Apply one command to the shadow state and work out the result it yields
   task automatic resolve_command(input stim_row_type s, output vis_pkg::rsp_type r);
      logic [5:0] pick;
      int         idx;
      int         v;
      r    = '0;
      pick = '0;
      idx  = int'(s.off) / 4;
      case (s.cmd)
         vis_pkg::CMD_SET_PENDING: begin
            pend_bits[s.vec] = 1'b1;
            recheck_bit      = 1'b1;
         end
         vis_pkg::CMD_SCB_READ: begin
            case (s.off)
               vis_pkg::OFF_ICSR:     r.read_data = icsr_word;
               vis_pkg::OFF_VTOR:     r.read_data = vtor_word;
               vis_pkg::OFF_SHPR3:    r.read_data = shpr3_word;
               vis_pkg::OFF_SHCSR:    r.read_data = shcsr_word;
               vis_pkg::OFF_MPU_TYPE: r.read_data = vis_pkg::MPU_TYPE_VALUE;
               default:               r.read_data = '0;
            endcase
         end
         vis_pkg::CMD_SCB_WRITE: begin
            case (s.off)
               vis_pkg::OFF_ICSR: begin
                  icsr_word   = s.data;
                  recheck_bit = 1'b1;
               end
               vis_pkg::OFF_VTOR:  vtor_word  = s.data;
               vis_pkg::OFF_SHPR3: shpr3_word = s.data;
               vis_pkg::OFF_SHCSR: shcsr_word = s.data;
               default: ;
            endcase
         end
         vis_pkg::CMD_ENABLE_READ: begin
            if (idx < vis_pkg::ENABLE_WORDS_DEF) r.read_data = enable_bits[idx];
         end
         vis_pkg::CMD_ENABLE_WRITE: begin
            if (idx < vis_pkg::ENABLE_WORDS_DEF)
               enable_bits[idx] = enable_bits[idx] | s.data;
         end
         vis_pkg::CMD_EVALUATE: begin
            recheck_bit = 1'b0;
            if (icsr_word[vis_pkg::PENDSV_SET_BIT]) pend_bits[vis_pkg::VEC_PENDSV] = 1'b1;
            if (pend_bits == '0 || s.hold != 3'b000) begin
               recheck_bit = (pend_bits != '0);
            end else if (pend_bits[vis_pkg::VEC_SVC]) begin
               pick = vis_pkg::VEC_SVC;
            end else if (pend_bits[vis_pkg::VEC_SYSTICK]) begin
               pick = vis_pkg::VEC_SYSTICK;
            end else if (pend_bits[vis_pkg::VEC_PENDSV]) begin
               pick = vis_pkg::VEC_PENDSV;
               icsr_word[vis_pkg::PENDSV_SET_BIT] = 1'b0;
            end else begin
               for (v = vis_pkg::FIRST_EXTERNAL; v < vis_pkg::LAST_VECTOR_DEF; v++) begin
                  if (pick == '0 && pend_bits[v] &&
                      enable_bits[(v - vis_pkg::FIRST_EXTERNAL) / 32]
                                 [(v - vis_pkg::FIRST_EXTERNAL) % 32])
                     pick = 6'(v);
               end
            end
            if (pick != '0) pend_bits[pick] = 1'b0;
         end
         default: ;
      endcase
      r.take_valid     = (pick != '0);
      r.take_vector    = pick;
      r.recheck_needed = recheck_bit;
   endtask

   function automatic logic [7:0] scb_offset();
      case ($urandom_range(6))
         0:       return vis_pkg::OFF_ICSR;
         1:       return vis_pkg::OFF_VTOR;
         2:       return vis_pkg::OFF_SHPR3;
         3:       return vis_pkg::OFF_SHCSR;
         4:       return vis_pkg::OFF_MPU_TYPE;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed traffic: pending marks on selectable vectors, evaluates, sparse enables
   function automatic stim_row_type random_row();
      stim_row_type s;
      int           pick;
      s       = '0;
      s.vec   = 6'($urandom);
      s.off   = 8'($urandom);
      s.data  = $urandom;
      s.hold  = ($urandom_range(99) < 25) ? 3'($urandom_range(7, 1)) : 3'b000;
      pick    = $urandom_range(99);
      if (pick < 25) begin
         s.cmd = vis_pkg::CMD_SET_PENDING;
         case ($urandom_range(3))
            0:       s.vec = ($urandom_range(2) == 0) ? vis_pkg::VEC_SVC :
                             ($urandom_range(1) == 0) ? vis_pkg::VEC_PENDSV :
                                                        vis_pkg::VEC_SYSTICK;
            1, 2:    s.vec = 6'($urandom_range(vis_pkg::LAST_VECTOR_DEF - 1,
                                               vis_pkg::FIRST_EXTERNAL));
            default: ;
         endcase
      end else if (pick < 55) begin
         s.cmd = vis_pkg::CMD_EVALUATE;
      end else if (pick < 66) begin
         s.cmd = vis_pkg::CMD_SCB_READ;
         s.off = scb_offset();
      end else if (pick < 76) begin
         s.cmd = vis_pkg::CMD_SCB_WRITE;
         s.off = scb_offset();
      end else if (pick < 86) begin
         s.cmd = vis_pkg::CMD_ENABLE_READ;
         if ($urandom_range(3) != 0) s.off = 8'($urandom_range(15));
      end else begin
         s.cmd = vis_pkg::CMD_ENABLE_WRITE;
         if ($urandom_range(3) != 0) s.off = 8'($urandom_range(11));
         if ($urandom_range(9) != 0) s.data = 32'(1) << $urandom_range(31);
      end
      return s;
   endfunction

   // Offer one transaction and return at the edge where it is taken
   task automatic offer(input stim_row_type s);
      vis_pkg::rsp_type r;
      while (gaps_on && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.cmd;
      req_tdata  <= {7'd0, s.hold, s.data, s.off, s.vec};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      resolve_command(s, r);
      expected_outcomes.push_back(s.fixed ? s.want : r);
   endtask

   task automatic drain_and_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Result check: oldest expectation first
   always @(posedge clock) begin
      vis_pkg::rsp_type got;
      vis_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(got), '0);
         end else begin
            want = expected_outcomes.pop_front();
            if (got.read_data != want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
            if (got.take_valid != want.take_valid)
               report_mismatch("take_valid", 32'(got.take_valid), 32'(want.take_valid));
            if (got.take_vector != want.take_vector)
               report_mismatch("take_vector", 32'(got.take_vector), 32'(want.take_vector));
            if (got.recheck_needed != want.recheck_needed)
               report_mismatch("recheck_needed", 32'(got.recheck_needed),
                               32'(want.recheck_needed));
         end
      end
   end

   // Result side: random back-pressure, plus one long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(99) < 26);
         end
      end
   end

   initial begin
      vis_pkg::rsp_type z;
      z = '0;
      clear_state();

      directed_rows.push_back(row(vis_pkg::CMD_SCB_READ, 6'd0, vis_pkg::OFF_ICSR, '0,
                                  3'b000, 1'b1, z));
      directed_rows.push_back(row(vis_pkg::CMD_SCB_READ, 6'd0, vis_pkg::OFF_MPU_TYPE, '0,
                                  3'b000, 1'b1,
                                  outcome(vis_pkg::MPU_TYPE_VALUE, 1'b0, 6'd0, 1'b0)));
      directed_rows.push_back(row(vis_pkg::CMD_SCB_READ, 6'd63, 8'hFF, '1, 3'b000, 1'b1, z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_READ, 6'd0, 8'hFC, '1, 3'b000, 1'b1,
                                  z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b111, 1'b1, z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_WRITE, 6'd0, 8'h00, 32'hFFFF_FFFF,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_WRITE, 6'd0, 8'h07, 32'h0000_01FF,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_WRITE, 6'd0, 8'h0B, 32'hA5A5_A5A5,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_WRITE, 6'd0, 8'hFF, 32'hFFFF_FFFF,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_READ, 6'd0, 8'h04, '0, 3'b000, 1'b0,
                                  z));
      directed_rows.push_back(row(vis_pkg::CMD_ENABLE_READ, 6'd0, 8'h0A, '0, 3'b000, 1'b0,
                                  z));
      // Unselectable vectors stay pending and never get taken
      directed_rows.push_back(row(vis_pkg::CMD_SET_PENDING, 6'd0, 8'h00, '0, 3'b000, 1'b0,
                                  z));
      directed_rows.push_back(row(vis_pkg::CMD_SET_PENDING, 6'd63, 8'h00, '0, 3'b000, 1'b0,
                                  z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_SET_PENDING, vis_pkg::VEC_SVC, 8'h00, '0,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_SET_PENDING, vis_pkg::VEC_SYSTICK, 8'h00, '0,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b001, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b010, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b000, 1'b0, z));
      // PendSV through the ICSR set bit, which the take clears again
      directed_rows.push_back(row(vis_pkg::CMD_SCB_WRITE, 6'd0, vis_pkg::OFF_ICSR,
                                  32'hFFFF_FFFF, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_SCB_READ, 6'd0, vis_pkg::OFF_ICSR, '0,
                                  3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_SET_PENDING, 6'd56, 8'h00, '0, 3'b000, 1'b0,
                                  z));
      directed_rows.push_back(row(vis_pkg::CMD_SET_PENDING, 6'd16, 8'h00, '0, 3'b000, 1'b0,
                                  z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b100, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_EVALUATE, 6'd0, 8'h00, '0, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_SCB_WRITE, 6'd0, vis_pkg::OFF_VTOR,
                                  32'hFFFF_FFFF, 3'b000, 1'b0, z));
      directed_rows.push_back(row(vis_pkg::CMD_SCB_READ, 6'd0, vis_pkg::OFF_VTOR, '0,
                                  3'b000, 1'b0, z));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) offer(directed_rows[i]);
      drain_and_wait();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) drain_and_wait();
         gaps_on = !(n >= 150 && n < 250);
         if (n == 300) hold_request = 1'b1;
         offer(random_row());
      end

      drain_and_wait();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("vectored_interrupt_selector_tb: done, clean");
      end else begin
         $display("vectored_interrupt_selector_tb: done, errors");
      end
      $finish;
   end

endmodule
